// File: sv/lspd_pkg.sv
// Package for the line sensor position decoder.
// Holds widths, reset thresholds, the frame struct and the pattern-to-position table.
// No dependencies.
`default_nettype none

package lspd_pkg;

    localparam int SlotCount = 8;
    localparam int SlotW     = 3;
    localparam int SampleW   = 8;
    localparam int ThreshW   = 10;
    localparam int CodeW     = 5;
    localparam int CountW    = 4;
    localparam int CfgIdxW   = 4;

    localparam logic [CodeW-1:0]   NoLine   = 5'd31;
    localparam logic [SlotW-1:0]   LastSlot = 3'(SlotCount - 1);

    localparam logic [ThreshW-1:0] ThreshReset [SlotCount] = '{
        10'd650, 10'd700, 10'd700, 10'd725, 10'd725, 10'd700, 10'd700, 10'd650
    };

    // Completed frame handed from the accumulator to the output stage
    typedef struct packed {
        logic                 done;
        logic [SlotCount-1:0] pattern;
        logic [CountW-1:0]    count;
    } t_frame;

    typedef struct packed {
        logic             hit;
        logic [CodeW-1:0] code;
    } t_lookup;

    function automatic t_lookup lookup_code(input logic [SlotCount-1:0] pattern);
        t_lookup r;
        r.hit  = 1'b1;
        r.code = NoLine;
        case (pattern)
            8'h80: r.code = 5'd1;
            8'hC0: r.code = 5'd2;
            8'hE0: r.code = 5'd3;
            8'h40: r.code = 5'd4;
            8'h60: r.code = 5'd5;
            8'h70: r.code = 5'd6;
            8'h20: r.code = 5'd7;
            8'h30: r.code = 5'd8;
            8'h10: r.code = 5'd9;
            8'h38: r.code = 5'd10;
            8'h18: r.code = 5'd11;
            8'h1C: r.code = 5'd12;
            8'h08: r.code = 5'd13;
            8'h0C: r.code = 5'd14;
            8'h04: r.code = 5'd15;
            8'h0E: r.code = 5'd16;
            8'h06: r.code = 5'd17;
            8'h02: r.code = 5'd18;
            8'h07: r.code = 5'd19;
            8'h03: r.code = 5'd20;
            8'h01: r.code = 5'd21;
            8'hF0: r.code = 5'd22;
            8'hF8: r.code = 5'd23;
            8'hFC: r.code = 5'd24;
            8'hFE: r.code = 5'd25;
            8'hFF: r.code = 5'd26;
            8'h7F: r.code = 5'd27;
            8'h3F: r.code = 5'd28;
            8'h1F: r.code = 5'd29;
            8'h0F: r.code = 5'd30;
            8'h00: r.code = NoLine;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/lspd_thresh.sv
// Per-slot threshold registers with write port and slot-indexed read.
// Depends on lspd_pkg.
`default_nettype none

module lspd_thresh (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_valid,
    input  wire  [lspd_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire  [lspd_pkg::ThreshW-1:0]  i_cfg_data,
    input  wire  [lspd_pkg::SlotW-1:0]    i_slot,
    output logic [lspd_pkg::ThreshW-1:0]  o_thresh
);
    import lspd_pkg::*;

    logic [ThreshW-1:0] r_thresh [SlotCount];
    logic               wr_en;

    assign wr_en = i_cfg_valid && (i_cfg_index < CfgIdxW'(SlotCount));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SlotCount; i++) begin
                r_thresh[i] <= ThreshReset[i];
            end
        end else if (wr_en) begin
            r_thresh[i_cfg_index[SlotW-1:0]] <= i_cfg_data;
        end
    end

    assign o_thresh = r_thresh[i_slot];

endmodule

`default_nettype wire

// File: sv/lspd_acc.sv
// Input register, slot counter and per-frame pattern/hit accumulation.
// Depends on lspd_pkg; threshold comes from lspd_thresh.
`default_nettype none

module lspd_acc (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire  [lspd_pkg::SampleW-1:0]  i_sample_high_byte,
    input  wire                           i_out_busy,
    output logic [lspd_pkg::SlotW-1:0]    o_slot,
    input  wire  [lspd_pkg::ThreshW-1:0]  i_thresh,
    output lspd_pkg::t_frame              o_frame
);
    import lspd_pkg::*;

    logic                 r_vld;
    logic [SampleW-1:0]   r_sample;
    logic [SlotW-1:0]     r_slot;
    logic [SlotCount-1:0] r_pattern;
    logic [CountW-1:0]    r_count;

    logic                 hit;
    logic                 frame_end;
    logic                 fire;
    logic [SlotCount-1:0] n_pattern;
    logic [CountW-1:0]    n_count;

    assign hit       = {r_sample, 2'b00} > i_thresh;
    assign frame_end = (r_slot == LastSlot);
    assign fire      = r_vld && !(frame_end && i_out_busy);
    assign o_in_stall = r_vld && !fire;
    assign o_slot    = r_slot;

    always_comb begin
        n_pattern = r_pattern;
        n_count   = r_count;
        if (hit) begin
            n_pattern[LastSlot - r_slot] = 1'b1;
            n_count = r_count + CountW'(1);
        end
    end

    always_comb begin
        o_frame.done    = fire && frame_end;
        o_frame.pattern = n_pattern;
        o_frame.count   = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_sample <= i_sample_high_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_slot    <= '0;
            r_pattern <= '0;
            r_count   <= '0;
        end else begin
            if (!o_in_stall) begin
                r_vld <= i_in_valid;
            end
            if (fire) begin
                if (frame_end) begin
                    r_slot    <= '0;
                    r_pattern <= '0;
                    r_count   <= '0;
                end else begin
                    r_slot    <= r_slot + SlotW'(1);
                    r_pattern <= n_pattern;
                    r_count   <= n_count;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/lspd_frame.sv
// Frame-end position lookup, current/prior position state and result register.
// Depends on lspd_pkg; frames come from lspd_acc.
`default_nettype none

module lspd_frame (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire lspd_pkg::t_frame        i_frame,
    input  wire                          i_out_stall,
    output logic                         o_out_busy,
    output logic                         o_out_valid,
    output logic [lspd_pkg::CodeW-1:0]   o_position_code,
    output logic [lspd_pkg::CodeW-1:0]   o_previous_position,
    output logic [lspd_pkg::SlotCount-1:0] o_frame_pattern,
    output logic [lspd_pkg::CountW-1:0]  o_active_count
);
    import lspd_pkg::*;

    logic                 r_out_valid;
    logic [CodeW-1:0]     r_cur;
    logic [CodeW-1:0]     r_prior;
    logic [CodeW-1:0]     r_out_prior;
    logic [SlotCount-1:0] r_out_pattern;
    logic [CountW-1:0]    r_out_count;

    t_lookup              lk;
    logic [CodeW-1:0]     n_cur;
    logic [CodeW-1:0]     n_prior;

    assign lk      = lookup_code(i_frame.pattern);
    assign n_prior = (r_cur != NoLine) ? r_cur : r_prior;
    assign n_cur   = lk.hit ? lk.code : r_cur;

    assign o_out_busy = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cur       <= NoLine;
            r_prior     <= NoLine;
        end else begin
            if (i_frame.done) begin
                r_out_valid <= 1'b1;
                r_cur       <= n_cur;
                r_prior     <= n_prior;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.done) begin
            r_out_prior   <= n_prior;
            r_out_pattern <= i_frame.pattern;
            r_out_count   <= i_frame.count;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_position_code     = r_cur;
    assign o_previous_position = r_out_prior;
    assign o_frame_pattern     = r_out_pattern;
    assign o_active_count      = r_out_count;

endmodule

`default_nettype wire

// File: sv/line_sensor_position_decoder.sv
// Top level of the eight-channel line sensor position decoder.
// Depends on lspd_pkg, lspd_thresh, lspd_acc, lspd_frame.
//
//   channel  direction  handshake             payload
//   in       sink       i_in_valid/o_in_stall  i_sample_high_byte
//   out      source     o_out_valid/i_out_stall position, previous, pattern, count
//   cfg      sink       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One sample per cycle unless o_in_stall; each sample passes through the input register
// (compare and bit set), and the eighth beat of a frame loads the result register.
// A frame result is loaded from its slot-7 sample in the input register.
// Reset is synchronous: slot 0, empty pattern, positions 31, thresholds to defaults.
// A held result stalls the input only when a new slot-7 sample would overwrite it.
`default_nettype none

module line_sensor_position_decoder (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  [lspd_pkg::SampleW-1:0]     i_sample_high_byte,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [lspd_pkg::CodeW-1:0]       o_position_code,
    output logic [lspd_pkg::CodeW-1:0]       o_previous_position,
    output logic [lspd_pkg::SlotCount-1:0]   o_frame_pattern,
    output logic [lspd_pkg::CountW-1:0]      o_active_count,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [lspd_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  wire  [lspd_pkg::ThreshW-1:0]     i_cfg_data
);
    import lspd_pkg::*;

    logic [SlotW-1:0]   slot;
    logic [ThreshW-1:0] thresh;
    logic               out_busy;
    t_frame             frame;

    assign o_cfg_ready = 1'b1;

    lspd_thresh u_thresh (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_slot      (slot),
        .o_thresh    (thresh)
    );

    lspd_acc u_acc (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_sample_high_byte (i_sample_high_byte),
        .i_out_busy         (out_busy),
        .o_slot             (slot),
        .i_thresh           (thresh),
        .o_frame            (frame)
    );

    lspd_frame u_frame (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_frame             (frame),
        .i_out_stall         (i_out_stall),
        .o_out_busy          (out_busy),
        .o_out_valid         (o_out_valid),
        .o_position_code     (o_position_code),
        .o_previous_position (o_previous_position),
        .o_frame_pattern     (o_frame_pattern),
        .o_active_count      (o_active_count)
    );

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($countones(o_frame_pattern) == 32'(o_active_count)))
        else $error("active count does not match pattern");

    a_empty_no_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_frame_pattern == '0)) |-> (o_position_code == NoLine))
        else $error("empty frame without no-line code");

    a_frame_only_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame.done |-> (slot == LastSlot))
        else $error("frame completed off the last slot");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame.done |=> o_out_valid)
        else $error("completed frame not presented");

endmodule

`default_nettype wire

// File: dv/line_sensor_position_decoder_tb.sv
// Self-checking testbench for line_sensor_position_decoder: sample beats in, frame results out,
// threshold writes on the config channel, checked against an in-bench decoder and typed rows.
// Depends on lspd_pkg and the line_sensor_position_decoder RTL.
`timescale 1ns / 100ps

module line_sensor_position_decoder_tb;

    import lspd_pkg::*;

    localparam int IdleLimit      = 2000;
    localparam int LongHold       = 48;
    localparam int DrainCycles    = 4;
    localparam int EndSettle      = 8;
    localparam int ThreshRegBase  = 0;
    localparam int FirstUnusedReg = SlotCount;
    localparam int LastReg        = (1 << CfgIdxW) - 1;

    // Position table, code c at bits [(c-1)*8 +: 8]
    localparam logic [31*8-1:0] PosTable = {
        8'h00, 8'h0F, 8'h1F, 8'h3F, 8'h7F, 8'hFF, 8'hFE, 8'hFC,
        8'hF8, 8'hF0, 8'h01, 8'h03, 8'h07, 8'h02, 8'h06, 8'h0E,
        8'h04, 8'h0C, 8'h08, 8'h1C, 8'h18, 8'h38, 8'h10, 8'h30,
        8'h20, 8'h70, 8'h60, 8'h40, 8'hE0, 8'hC0, 8'h80
    };

    typedef enum int {ThrDefault, ThrAllLow, ThrAllHigh, ThrRandom, ThrMixed} t_thr_setting;

    typedef struct packed {
        logic [CodeW-1:0]     position;
        logic [CodeW-1:0]     previous;
        logic [SlotCount-1:0] pattern;
        logic [CountW-1:0]    count;
    } t_frame_result;

    typedef struct packed {
        logic          typed;
        t_frame_result result;
    } t_frame_note;

    typedef struct packed {
        logic [SlotCount*SampleW-1:0] samples;
        t_frame_note                  note;
    } t_dir_row;

    logic                   i_clk;
    logic                   i_rst_n            = 1'b0;
    logic                   i_in_valid         = 1'b0;
    logic [SampleW-1:0]     i_sample_high_byte = '0;
    logic                   i_out_stall        = 1'b0;
    logic                   i_cfg_valid        = 1'b0;
    logic [CfgIdxW-1:0]     i_cfg_index        = '0;
    logic [ThreshW-1:0]     i_cfg_data         = '0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [CodeW-1:0]       o_position_code;
    logic [CodeW-1:0]       o_previous_position;
    logic [SlotCount-1:0]   o_frame_pattern;
    logic [CountW-1:0]      o_active_count;
    logic                   o_cfg_ready;

    // Decoder copy
    logic [ThreshW-1:0]     slot_thresh [SlotCount];
    logic [SlotW-1:0]       cur_slot;
    logic [SlotCount-1:0]   acc_pattern;
    logic [CountW-1:0]      acc_hits;
    logic [CodeW-1:0]       cur_code;
    logic [CodeW-1:0]       prev_code;

    t_frame_result          frame_results_q [$];
    t_frame_note            typed_q [$];

    bit tx_no_gaps    = 1'b0;
    bit rx_no_gaps    = 1'b0;
    bit hold_off_req  = 1'b0;
    int failures      = 0;
    int samples_in    = 0;
    int frames_seen   = 0;
    int reg_writes    = 0;
    int idle_cycles   = 0;

    line_sensor_position_decoder DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_sample_high_byte  (i_sample_high_byte),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_position_code     (o_position_code),
        .o_previous_position (o_previous_position),
        .o_frame_pattern     (o_frame_pattern),
        .o_active_count      (o_active_count),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // {found, code}
    function automatic logic [CodeW:0] look_up_position(input logic [SlotCount-1:0] pat);
        for (int c = 1; c <= 31; c++) begin
            if (PosTable[(c-1)*8 +: 8] == pat) begin
                return {1'b1, CodeW'(c)};
            end
        end
        return '0;
    endfunction

    task automatic clear_decoder();
        for (int s = 0; s < SlotCount; s++) begin
            slot_thresh[s] = ThreshReset[s];
        end
        cur_slot    = '0;
        acc_pattern = '0;
        acc_hits    = '0;
        cur_code    = NoLine;
        prev_code   = NoLine;
    endtask

    task automatic decode_sample(input logic [SampleW-1:0] smp);
        logic [CodeW:0] hit;
        t_frame_result  res;
        t_frame_note    note;
        if ({smp, 2'b00} > slot_thresh[cur_slot]) begin
            acc_pattern[SlotCount-1-cur_slot] = 1'b1;
            acc_hits = acc_hits + 1'b1;
        end
        if (cur_slot != LastSlot) begin
            cur_slot = cur_slot + 1'b1;
        end else begin
            if (cur_code != NoLine) begin
                prev_code = cur_code;
            end
            hit = look_up_position(acc_pattern);
            if (hit[CodeW]) begin
                cur_code = hit[CodeW-1:0];
            end
            res = '{cur_code, prev_code, acc_pattern, acc_hits};
            if (typed_q.size() > 0) begin
                note = typed_q.pop_front();
                if (note.typed) begin
                    res = note.result;
                end
            end
            frame_results_q.push_back(res);
            cur_slot    = '0;
            acc_pattern = '0;
            acc_hits    = '0;
        end
    endtask

    always @(posedge i_clk) begin : beat_monitor
        logic          in_beat;
        logic          out_beat;
        logic          cfg_beat;
        t_frame_result exp;
        in_beat  = i_in_valid && !o_in_stall;
        out_beat = o_out_valid && !i_out_stall;
        cfg_beat = i_cfg_valid && o_cfg_ready;
        if (!i_rst_n) begin
            clear_decoder();
        end else begin
            if (cfg_beat) begin
                reg_writes++;
                if (i_cfg_index < SlotCount) begin
                    slot_thresh[i_cfg_index] = i_cfg_data;
                end
            end
            if (in_beat) begin
                samples_in++;
                decode_sample(i_sample_high_byte);
            end
            if (out_beat) begin
                frames_seen++;
                if (frame_results_q.size() == 0) begin
                    $error("frame result with none expected");
                    failures++;
                end else begin
                    exp = frame_results_q.pop_front();
                    if (o_position_code !== exp.position) begin
                        $error("position_code: expected %0d, got %0d",
                               exp.position, o_position_code);
                        failures++;
                    end
                    if (o_previous_position !== exp.previous) begin
                        $error("previous_position: expected %0d, got %0d",
                               exp.previous, o_previous_position);
                        failures++;
                    end
                    if (o_frame_pattern !== exp.pattern) begin
                        $error("frame_pattern: expected %h, got %h",
                               exp.pattern, o_frame_pattern);
                        failures++;
                    end
                    if (o_active_count !== exp.count) begin
                        $error("active_count: expected %0d, got %0d",
                               exp.count, o_active_count);
                        failures++;
                    end
                end
            end
            if (in_beat || out_beat || cfg_beat) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IdleLimit) begin
                $display("Timeout: no beat for %0d cycles", IdleLimit);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Result side
    initial begin : result_sink
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LongHold) @(posedge i_clk);
            end
            gap = rx_no_gaps ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    task automatic send_sample(input logic [SampleW-1:0] smp);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_sample_high_byte <= smp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (frame_results_q.size() > 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ThreshW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic load_thresholds(input t_thr_setting kind);
        logic [ThreshW-1:0] val;
        for (int s = 0; s < SlotCount; s++) begin
            case (kind)
                ThrDefault: val = ThreshReset[s];
                ThrAllLow:  val = '0;
                ThrAllHigh: val = '1;
                ThrRandom:  val = ThreshW'($urandom_range(0, (1 << ThreshW) - 1));
                default: begin
                    case ($urandom_range(0, 2))
                        0:       val = '0;
                        1:       val = '1;
                        default: val = ThreshW'($urandom_range(0, (1 << ThreshW) - 1));
                    endcase
                end
            endcase
            write_reg(CfgIdxW'(ThreshRegBase + s), val);
        end
        if (kind == ThrAllLow) begin
            // out-of-range indexes must leave the thresholds alone
            write_reg(CfgIdxW'(FirstUnusedReg), '1);
            write_reg(CfgIdxW'(LastReg), '1);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [SampleW-1:0] pick_sample(input int slot, input bit want_hit);
        int limit;
        limit = int'(slot_thresh[slot] >> 2);
        if (want_hit && limit < 255) begin
            return ($urandom_range(0, 3) == 0) ? SampleW'(limit + 1)
                                               : SampleW'($urandom_range(limit + 1, 255));
        end
        return ($urandom_range(0, 3) == 0) ? SampleW'(limit) : SampleW'($urandom_range(0, limit));
    endfunction

    task automatic send_random_frames(input int n, input bit mixed_idling);
        logic [SlotCount-1:0] pat;
        int                   idx;
        for (int f = 0; f < n; f++) begin
            if (mixed_idling) begin
                tx_no_gaps = ($urandom_range(0, 3) == 0);
                rx_no_gaps = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 9) < 7) begin
                idx = $urandom_range(0, 30);
                pat = PosTable[idx*8 +: 8];
            end else begin
                pat = SlotCount'($urandom_range(0, 255));
            end
            for (int s = 0; s < SlotCount; s++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_sample(SampleW'($urandom_range(0, 255)));
                end else begin
                    send_sample(pick_sample(s, pat[SlotCount-1-s]));
                end
            end
        end
    endtask

    initial begin : stimulus
        t_dir_row dir_rows [4];

        // reset thresholds: 650 needs 163, 700 needs 176, 725 needs 182 to hit
        dir_rows[0] = {64'h0000_0000_0000_0000, 1'b1, 5'd31, 5'd31, 8'h00, 4'd0};
        dir_rows[1] = {64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 5'd26, 5'd31, 8'hFF, 4'd8};
        dir_rows[2] = {64'h0000_0000_0000_0000, 1'b1, 5'd31, 5'd26, 8'h00, 4'd0};
        // ties on slots 1 and 6, pattern A5 is not in the table
        dir_rows[3] = {64'hA3AF_B0B5_00B0_AFA3, 1'b0, 5'd0, 5'd0, 8'h00, 4'd0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < 4; r++) begin
            typed_q.push_back(dir_rows[r].note);
        end
        for (int r = 0; r < 4; r++) begin
            for (int s = 0; s < SlotCount; s++) begin
                send_sample(dir_rows[r].samples[SlotCount*SampleW-1-SampleW*s -: SampleW]);
            end
        end

        wait_drained();
        send_random_frames(15, 1'b0);

        wait_drained();
        load_thresholds(ThrAllLow);
        send_random_frames(8, 1'b0);

        wait_drained();
        load_thresholds(ThrAllHigh);
        send_random_frames(6, 1'b0);

        // back-to-back beats against a long output hold
        wait_drained();
        load_thresholds(ThrRandom);
        tx_no_gaps   = 1'b1;
        rx_no_gaps   = 1'b1;
        hold_off_req = 1'b1;
        send_random_frames(15, 1'b0);
        tx_no_gaps = 1'b0;
        rx_no_gaps = 1'b0;

        wait_drained();
        load_thresholds(ThrMixed);
        send_random_frames(20, 1'b1);
        tx_no_gaps = 1'b0;
        rx_no_gaps = 1'b0;

        wait_drained();
        repeat (EndSettle) @(posedge i_clk);
        if (frame_results_q.size() > 0) begin
            $error("%0d expected frame results never arrived", frame_results_q.size());
            failures++;
        end

        $display("Run covered %0d samples, %0d frame results and %0d register writes,",
                 samples_in, frames_seen, reg_writes);
        $display("over default, zero, full-scale, random and mixed threshold settings.");
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: line_sensor_position_decoder.f
sv/lspd_pkg.sv
sv/lspd_thresh.sv
sv/lspd_acc.sv
sv/lspd_frame.sv
sv/line_sensor_position_decoder.sv
dv/line_sensor_position_decoder_tb.sv
